// ===== hdl/pif_pkg.sv =====
// Package for the printf integer field formatter: shared types, ASCII constants,
// the sequencer control word and the microcode table.
// No dependencies.
package pif_pkg;

    // Digit store: ten BCD digits cover the full 32-bit range
    localparam int NDIG   = 10;
    localparam int DIG_W  = 4;
    localparam int IDX_W  = $clog2(NDIG);
    localparam int BIN_W  = 32;
    localparam int ITER_W = $clog2(BIN_W + 1);
    localparam int PC_W   = 4;

    // ASCII codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef enum logic [1:0] {
        FUNC_SDEC = 2'd0,
        FUNC_UDEC = 2'd1,
        FUNC_HEXL = 2'd2,
        FUNC_HEXU = 2'd3
    } func_t;

    typedef logic [NDIG-1:0][DIG_W-1:0] digits_t;

    // Microcode fields
    typedef enum logic [1:0] {
        OP_WAIT  = 2'd0,
        OP_CONV  = 2'd1,
        OP_SETUP = 2'd2,
        OP_EMIT  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_IN_FIRE  = 2'd1,
        COND_CONV_END = 2'd2,
        COND_RUN_ZERO = 2'd3
    } cond_t;

    typedef enum logic [2:0] {
        SRC_LEAD  = 3'd0,
        SRC_SIGN  = 3'd1,
        SRC_ZPAD  = 3'd2,
        SRC_PZERO = 3'd3,
        SRC_DIG   = 3'd4,
        SRC_TRAIL = 3'd5
    } src_t;

    typedef enum logic [1:0] {
        CHR_SPACE = 2'd0,
        CHR_MINUS = 2'd1,
        CHR_ZERO  = 2'd2,
        CHR_DIGIT = 2'd3
    } chr_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        src_t            src;
        chr_t            chr;
        logic [PC_W-1:0] nxt;
    } ctrl_t;

    // Status flags fed back to the sequencer
    typedef struct packed {
        logic in_fire;
        logic conv_done;
        logic run_zero;
    } flags_t;

    // Microcode ROM: jump to nxt when cond holds, otherwise hold the step
    function automatic ctrl_t ucode(input logic [PC_W-1:0] addr);
        ctrl_t w;
        w = '{op: OP_WAIT, cond: COND_IN_FIRE, src: SRC_LEAD, chr: CHR_SPACE,
              nxt: PC_W'(1)};
        case (addr)
            PC_W'(0): w = '{OP_WAIT,  COND_IN_FIRE,  SRC_LEAD,  CHR_SPACE, PC_W'(1)};
            PC_W'(1): w = '{OP_CONV,  COND_CONV_END, SRC_LEAD,  CHR_SPACE, PC_W'(2)};
            PC_W'(2): w = '{OP_SETUP, COND_ALWAYS,   SRC_LEAD,  CHR_SPACE, PC_W'(3)};
            PC_W'(3): w = '{OP_EMIT,  COND_RUN_ZERO, SRC_LEAD,  CHR_SPACE, PC_W'(4)};
            PC_W'(4): w = '{OP_EMIT,  COND_RUN_ZERO, SRC_SIGN,  CHR_MINUS, PC_W'(5)};
            PC_W'(5): w = '{OP_EMIT,  COND_RUN_ZERO, SRC_ZPAD,  CHR_ZERO,  PC_W'(6)};
            PC_W'(6): w = '{OP_EMIT,  COND_RUN_ZERO, SRC_PZERO, CHR_ZERO,  PC_W'(7)};
            PC_W'(7): w = '{OP_EMIT,  COND_RUN_ZERO, SRC_DIG,   CHR_DIGIT, PC_W'(8)};
            PC_W'(8): w = '{OP_EMIT,  COND_RUN_ZERO, SRC_TRAIL, CHR_SPACE, PC_W'(0)};
            default:  w = '{OP_EMIT,  COND_ALWAYS,   SRC_LEAD,  CHR_SPACE, PC_W'(0)};
        endcase
        return w;
    endfunction

    // One digit to its ASCII character
    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
        logic [7:0] c;
        if (d < DIG_W'(10))
            c = CH_ZERO + 8'(d);
        else
            c = (upper ? CH_A_UP : CH_A_LO) + 8'(d - DIG_W'(10));
        return c;
    endfunction

endpackage

// ===== hdl/pif_b2d.sv =====
// Digit extractor: hex nibbles load directly, decimal goes through a
// shift-and-add-3 binary-to-BCD converter, one bit per cycle while step is high.
// Depends on pif_pkg.
module pif_b2d
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        load,
    input  logic                        hex,
    input  logic [pif_pkg::BIN_W-1:0]   mag,
    input  logic                        step,
    output pif_pkg::digits_t            digits,
    output logic                        done
);

    logic [pif_pkg::BIN_W-1:0]  bin_reg, bin_next;
    pif_pkg::digits_t           bcd_reg, bcd_next;
    logic [pif_pkg::ITER_W-1:0] iter_reg, iter_next;
    pif_pkg::digits_t           adj;

    // Add 3 to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < pif_pkg::NDIG; i++)
        begin
            adj[i] = (bcd_reg[i] >= pif_pkg::DIG_W'(5)) ?
                     bcd_reg[i] + pif_pkg::DIG_W'(3) : bcd_reg[i];
        end
    end

    // Load or iterate
    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        iter_next = iter_reg;
        if (load)
        begin
            if (hex)
            begin
                bcd_next  = pif_pkg::digits_t'({{(pif_pkg::NDIG * pif_pkg::DIG_W
                            - pif_pkg::BIN_W){1'b0}}, mag});
                bin_next  = '0;
                iter_next = '0;
            end
            else
            begin
                bcd_next  = '0;
                bin_next  = mag;
                iter_next = pif_pkg::ITER_W'(pif_pkg::BIN_W);
            end
        end
        else if (step && iter_reg != '0)
        begin
            {bcd_next, bin_next} = {adj, bin_reg} << 1;
            iter_next = iter_reg - pif_pkg::ITER_W'(1);
        end
    end

    // Iteration count is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= '0;
        else
            iter_reg <= iter_next;
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign digits = bcd_reg;
    assign done   = (iter_reg == '0);

endmodule

// ===== hdl/pif_seq.sv =====
// Microcoded sequencer: step counter, control ROM lookup and conditional jump.
// Depends on pif_pkg.
module pif_seq
(
    input  logic              clk,
    input  logic              rst_n,
    input  pif_pkg::flags_t   flags,
    output pif_pkg::ctrl_t    ctrl
);

    logic [pif_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                     cond_true;

    assign ctrl = pif_pkg::ucode(pc_reg);

    // Evaluate the jump condition of the current word
    always_comb
    begin
        case (ctrl.cond)
            pif_pkg::COND_ALWAYS:   cond_true = 1'b1;
            pif_pkg::COND_IN_FIRE:  cond_true = flags.in_fire;
            pif_pkg::COND_CONV_END: cond_true = flags.conv_done;
            pif_pkg::COND_RUN_ZERO: cond_true = flags.run_zero;
            default:                cond_true = 1'b1;
        endcase
        pc_next = cond_true ? ctrl.nxt : pc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= '0;
        else
            pc_reg <= pc_next;
    end

endmodule

// ===== hdl/printf_integer_field_formatter.sv =====
// printf-style integer field formatter (d, u, x, X). One request word in, the
// field's characters out one per word, last marked. The field is 0 to 61
// characters long. Decimal kinds first run the 32-iteration binary-to-decimal
// converter, while hex digits load directly; the single output register then
// takes one character per cycle while the output is not stalled, and moving on
// to each field segment takes a sequencer step of its own. A new request is taken
// only after the previous field has been fully queued to the output register.
// Depends on pif_pkg, pif_b2d, pif_seq.
module printf_integer_field_formatter
#(
    parameter int MAX_WIDTH     = 60,
    parameter int MAX_PRECISION = 60
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [31:0] value,
    input  logic [5:0]  width,
    input  logic [6:0]  precision,
    input  logic        zero_pad,
    input  logic        left_justify,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last
);

    localparam int MAX_LEN = (MAX_WIDTH > MAX_PRECISION + 1) ? MAX_WIDTH : MAX_PRECISION + 1;
    localparam int CW      = $clog2(MAX_LEN + 1);

    pif_pkg::ctrl_t   ctrl;
    pif_pkg::flags_t  flags;
    pif_pkg::digits_t digits;
    logic             conv_done;
    logic             in_fire;
    logic             is_sdec;
    logic             neg;
    logic [31:0]      mag;
    logic [5:0]       w_sat;
    logic [5:0]       p_sat;
    logic             prec_given;
    logic [CW-1:0]    prec_val;

    // Request registers
    logic             neg_reg;
    logic             upper_reg;
    logic             left_reg;
    logic             zp_reg;
    logic             zcase_reg;
    logic [CW-1:0]    w_reg;
    logic [CW-1:0]    prec_reg;

    // Segment run counters and output register
    logic [CW-1:0]    lead_reg, sign_reg, zpad_reg, pzero_reg, dig_reg, trail_reg;
    logic [CW-1:0]    remain_reg, remain_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             last_reg, last_next;

    // Setup values
    logic [CW-1:0]    ndig, len, pn, eff, pad, total, pz;
    logic [CW-1:0]    run_cur;
    logic             run_zero;
    logic             emit;
    logic             do_setup;
    logic [7:0]       char_sel;
    logic [pif_pkg::IDX_W-1:0] dig_idx;

    pif_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    pif_b2d u_b2d
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_fire),
        .hex    (func[1]),
        .mag    (mag),
        .step   (ctrl.op == pif_pkg::OP_CONV),
        .digits (digits),
        .done   (conv_done)
    );

    assign in_ready = (ctrl.op == pif_pkg::OP_WAIT);
    assign in_fire  = in_valid && in_ready;
    assign do_setup = (ctrl.op == pif_pkg::OP_SETUP);

    // Decode the request
    always_comb
    begin
        is_sdec    = (pif_pkg::func_t'(func) == pif_pkg::FUNC_SDEC);
        neg        = is_sdec && value[31];
        mag        = neg ? (32'd0 - value) : value;
        w_sat      = (width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width;
        prec_given = !precision[6];
        p_sat      = (precision[5:0] > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : precision[5:0];
        if (prec_given)
            prec_val = CW'(p_sat);
        else if (is_sdec)
            prec_val = '0;
        else
            prec_val = CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            neg_reg   <= neg;
            upper_reg <= (pif_pkg::func_t'(func) == pif_pkg::FUNC_HEXU);
            left_reg  <= left_justify;
            zp_reg    <= zero_pad && !prec_given && !left_justify;
            zcase_reg <= (value == 32'd0) && prec_given && (precision[5:0] == 6'd0);
            w_reg     <= CW'(w_sat);
            prec_reg  <= prec_val;
        end
    end

    // Digit count and segment lengths
    always_comb
    begin
        ndig = CW'(1);
        for (int i = 0; i < pif_pkg::NDIG; i++)
        begin
            if (digits[i] != '0)
                ndig = CW'(i + 1);
        end
        len   = ndig + CW'(neg_reg);
        pn    = prec_reg + CW'(neg_reg);
        eff   = (pn > len) ? pn : len;
        pad   = (w_reg > eff) ? w_reg - eff : '0;
        total = (w_reg > eff) ? w_reg : eff;
        pz    = (prec_reg > ndig) ? prec_reg - ndig : '0;
    end

    // Current run selected by the control word
    always_comb
    begin
        case (ctrl.src)
            pif_pkg::SRC_LEAD:  run_cur = lead_reg;
            pif_pkg::SRC_SIGN:  run_cur = sign_reg;
            pif_pkg::SRC_ZPAD:  run_cur = zpad_reg;
            pif_pkg::SRC_PZERO: run_cur = pzero_reg;
            pif_pkg::SRC_DIG:   run_cur = dig_reg;
            pif_pkg::SRC_TRAIL: run_cur = trail_reg;
            default:            run_cur = '0;
        endcase
        run_zero = (run_cur == '0);
    end

    assign flags = '{in_fire: in_fire, conv_done: conv_done, run_zero: run_zero};
    assign emit  = (ctrl.op == pif_pkg::OP_EMIT) && !run_zero &&
                   (!out_valid_reg || out_ready);

    // Character for the current step
    assign dig_idx = pif_pkg::IDX_W'(dig_reg - CW'(1));
    always_comb
    begin
        case (ctrl.chr)
            pif_pkg::CHR_SPACE: char_sel = pif_pkg::CH_SPACE;
            pif_pkg::CHR_MINUS: char_sel = pif_pkg::CH_MINUS;
            pif_pkg::CHR_ZERO:  char_sel = pif_pkg::CH_ZERO;
            pif_pkg::CHR_DIGIT: char_sel = pif_pkg::digit_char(digits[dig_idx], upper_reg);
            default:            char_sel = pif_pkg::CH_SPACE;
        endcase
    end

    // Run counters: loaded at setup, one count off per emitted character
    always_ff @(posedge clk)
    begin
        if (do_setup)
        begin
            if (zcase_reg)
            begin
                lead_reg  <= w_reg;
                sign_reg  <= '0;
                zpad_reg  <= '0;
                pzero_reg <= '0;
                dig_reg   <= '0;
                trail_reg <= '0;
            end
            else
            begin
                lead_reg  <= (!left_reg && !zp_reg) ? pad : '0;
                sign_reg  <= CW'(neg_reg);
                zpad_reg  <= zp_reg ? pad : '0;
                pzero_reg <= pz;
                dig_reg   <= ndig;
                trail_reg <= left_reg ? pad : '0;
            end
        end
        else if (emit)
        begin
            case (ctrl.src)
                pif_pkg::SRC_LEAD:  lead_reg  <= lead_reg - CW'(1);
                pif_pkg::SRC_SIGN:  sign_reg  <= sign_reg - CW'(1);
                pif_pkg::SRC_ZPAD:  zpad_reg  <= zpad_reg - CW'(1);
                pif_pkg::SRC_PZERO: pzero_reg <= pzero_reg - CW'(1);
                pif_pkg::SRC_DIG:   dig_reg   <= dig_reg - CW'(1);
                pif_pkg::SRC_TRAIL: trail_reg <= trail_reg - CW'(1);
                default:            lead_reg  <= lead_reg;
            endcase
        end
    end

    // Output register and remaining character count
    always_comb
    begin
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        last_next      = last_reg;
        if (do_setup)
            remain_next = zcase_reg ? w_reg : total;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next  = char_sel;
            last_next      = (remain_reg == CW'(1));
            remain_next    = remain_reg - CW'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        remain_reg   <= remain_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/pif_chk.sv =====
// Port-level checker for the printf integer field formatter, bound to the top level.
// No package dependencies.
module pif_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_char,
    input logic        last
);

    // A stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
        else $error("output word changed while stalled");

    // Only one request in flight
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken back to back");

    // No new request while a field is still being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("input ready in the middle of a field");

    // Output words carry printable ASCII only
    a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_char >= 8'h20) && (out_char <= 8'h7E))
        else $error("non-printable character on output");

endmodule

bind printf_integer_field_formatter pif_chk u_pif_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last      (last)
);

// ===== test/tb_printf_integer_field_formatter.sv =====
// Testbench for printf_integer_field_formatter: a queue-fed driver sends conversion
// requests in random bursts, and a monitor checks each output character against a local
// field predictor. Depends on pif_pkg and the formatter RTL.
`timescale 1ns / 1ps

module tb_printf_integer_field_formatter;

    localparam int FIELD_MAX = 60;      // width and precision saturation point
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 150;  // longest field plus converter latency
    localparam int RANDOM_ITEMS = 197;

    typedef struct {
        pif_pkg::func_t kind;
        logic [31:0]    value;
        logic [5:0]     width;
        logic [6:0]     precision;
        logic           zero_pad;
        logic           left_justify;
    } request_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } field_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = 2'd0;
    logic [31:0] value = 32'd0;
    logic [5:0]  width = 6'd0;
    logic [6:0]  precision = 7'd0;
    logic        zero_pad = 1'b0;
    logic        left_justify = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        last;

    request_t    request_q[$];
    field_char_t expected_chars[$];
    request_t    cur_req;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [31:0] ready_pattern = '1;
    int          pattern_left = 0;
    int          mismatches = 0;
    int          cycles = 0;

    printf_integer_field_formatter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value        (value),
        .width        (width),
        .precision    (precision),
        .zero_pad     (zero_pad),
        .left_justify (left_justify),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_char     (out_char),
        .last         (last)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    // Build the characters a request should produce and queue them
    function automatic void format_field(request_t r);
        logic [7:0]  line[$];
        logic [7:0]  digits[$];
        logic [31:0] mag;
        logic [31:0] base;
        logic [31:0] d;
        int          w;
        int          prec;
        int          eff;
        int          pad;
        logic        neg;
        logic        zero;
        field_char_t fc;
        w = (int'(r.width) > FIELD_MAX) ? FIELD_MAX : int'(r.width);
        prec = int'($signed(r.precision));
        if (prec > FIELD_MAX)
            prec = FIELD_MAX;
        if (prec < 0)
            prec = -1;
        zero = r.zero_pad && prec < 0 && !r.left_justify;
        neg = 1'b0;
        mag = r.value;
        if (r.kind == pif_pkg::FUNC_SDEC)
        begin
            neg = r.value[31];
            if (neg)
                mag = -r.value;
        end
        else if (prec < 0)
            prec = 1;

        if (mag == 0 && prec == 0)
        begin
            repeat (w) line.push_back(pif_pkg::CH_SPACE);
        end
        else
        begin
            base = (r.kind == pif_pkg::FUNC_HEXL || r.kind == pif_pkg::FUNC_HEXU) ?
                   32'd16 : 32'd10;
            // digits collected least significant first, so push to the front
            do
            begin
                d = mag % base;
                if (d < 10)
                    digits.push_front(pif_pkg::CH_ZERO + d[7:0]);
                else
                    digits.push_front(((r.kind == pif_pkg::FUNC_HEXU) ?
                                       pif_pkg::CH_A_UP : pif_pkg::CH_A_LO)
                                      + d[7:0] - 8'd10);
                mag = mag / base;
            end
            while (mag != 0);

            eff = digits.size() + (neg ? 1 : 0);
            if (prec + (neg ? 1 : 0) > eff)
                eff = prec + (neg ? 1 : 0);
            pad = (w > eff) ? w - eff : 0;

            if (!r.left_justify && !zero)
                repeat (pad) line.push_back(pif_pkg::CH_SPACE);
            if (neg)
                line.push_back(pif_pkg::CH_MINUS);
            if (zero)
                repeat (pad) line.push_back(pif_pkg::CH_ZERO);
            if (prec > digits.size())
                repeat (prec - digits.size()) line.push_back(pif_pkg::CH_ZERO);
            foreach (digits[i])
                line.push_back(digits[i]);
            if (r.left_justify)
                repeat (pad) line.push_back(pif_pkg::CH_SPACE);
        end

        foreach (line[i])
        begin
            fc.ch = line[i];
            fc.last = (i == line.size() - 1);
            expected_chars.push_back(fc);
        end
    endfunction

    task automatic add_request(pif_pkg::func_t kind, logic [31:0] v, logic [5:0] w,
                               logic [6:0] p, logic zp, logic lj);
        request_t r;
        r.kind = kind;
        r.value = v;
        r.width = w;
        r.precision = p;
        r.zero_pad = zp;
        r.left_justify = lj;
        request_q.push_back(r);
    endtask

    // Driver: sends queued words in bursts, holds a word until it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                format_field(cur_req);
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (request_q.size() > 0)
            begin
                cur_req = request_q.pop_front();
                func <= cur_req.kind;
                value <= cur_req.value;
                width <= cur_req.width;
                precision <= cur_req.precision;
                zero_pad <= cur_req.zero_pad;
                left_justify <= cur_req.left_justify;
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: ready follows a rotating pattern, reloaded now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (pattern_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = $urandom | $urandom;
                    2: ready_pattern = $urandom;
                    default: ready_pattern = $urandom & $urandom;
                endcase
                pattern_left = $urandom_range(16, 96);
            end
            out_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
            pattern_left--;
        end
    end

    // Monitor: compare each taken character with the oldest expectation
    always @(posedge clk)
    begin
        field_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected word: out_char %h last %b", out_char, last);
                mismatches++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    $error("out_char: expected %h, got %h", want.ch, out_char);
                    mismatches++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        request_t r;
        logic     timed_out;
        timed_out = 1'b0;

        // Directed: extremes, every kind, saturation and the special cases
        add_request(pif_pkg::FUNC_SDEC, 32'd0, 6'd0, 7'(-1), 1'b0, 1'b0);
        add_request(pif_pkg::FUNC_SDEC, 32'h8000_0000, 6'd0, 7'(-1), 1'b0, 1'b0);
        add_request(pif_pkg::FUNC_SDEC, 32'h7FFF_FFFF, 6'd0, 7'(-1), 1'b0, 1'b0);
        add_request(pif_pkg::FUNC_SDEC, 32'hFFFF_FFFF, 6'd12, 7'(-1), 1'b1, 1'b0);
        add_request(pif_pkg::FUNC_UDEC, 32'hFFFF_FFFF, 6'd63, 7'(-1), 1'b0, 1'b0);
        add_request(pif_pkg::FUNC_HEXL, 32'hDEAD_BEEF, 6'd10, 7'(-1), 1'b0, 1'b1);
        add_request(pif_pkg::FUNC_HEXU, 32'hCAFE_F00D, 6'd20, 7'(-1), 1'b1, 1'b0);
        // zero with precision zero: spaces only, or nothing at all
        add_request(pif_pkg::FUNC_SDEC, 32'd0, 6'd0, 7'd0, 1'b0, 1'b0);
        add_request(pif_pkg::FUNC_UDEC, 32'd0, 6'd5, 7'd0, 1'b1, 1'b0);
        add_request(pif_pkg::FUNC_HEXL, 32'd0, 6'd63, 7'd0, 1'b0, 1'b1);
        add_request(pif_pkg::FUNC_SDEC, 32'd0, 6'd7, 7'd0, 1'b0, 1'b1);
        // longest field: sign plus saturated precision
        add_request(pif_pkg::FUNC_SDEC, -32'd42, 6'd63, 7'd63, 1'b0, 1'b0);
        // negative precision other than -1 still means none
        add_request(pif_pkg::FUNC_SDEC, 32'd123, 6'd8, 7'h40, 1'b1, 1'b0);
        add_request(pif_pkg::FUNC_UDEC, 32'd7, 6'd6, 7'(-1), 1'b1, 1'b1);
        add_request(pif_pkg::FUNC_HEXU, 32'hABC, 6'd10, 7'd5, 1'b1, 1'b0);
        add_request(pif_pkg::FUNC_SDEC, -32'd5, 6'd6, 7'(-1), 1'b1, 1'b0);
        add_request(pif_pkg::FUNC_SDEC, -32'd5, 6'd6, 7'(-1), 1'b0, 1'b1);
        add_request(pif_pkg::FUNC_HEXL, 32'd0, 6'd0, 7'(-1), 1'b0, 1'b0);
        add_request(pif_pkg::FUNC_UDEC, 32'd1, 6'd0, 7'd60, 1'b0, 1'b0);
        add_request(pif_pkg::FUNC_HEXU, 32'hFFFF_FFFF, 6'd61, 7'd62, 1'b1, 1'b1);
        add_request(pif_pkg::FUNC_SDEC, 32'h8000_0000, 6'd30, 7'(-1), 1'b1, 1'b0);
        add_request(pif_pkg::FUNC_SDEC, 32'hFFFF_FFFF, 6'd63, 7'd10, 1'b0, 1'b1);
        add_request(pif_pkg::FUNC_UDEC, 32'd0, 6'd4, 7'(-1), 1'b1, 1'b0);

        // Random: mostly short fields, some wide, all value classes
        repeat (RANDOM_ITEMS)
        begin
            r.kind = pif_pkg::func_t'($urandom_range(0, 3));
            case ($urandom_range(0, 5))
                0: r.value = 32'd0;
                1: r.value = $urandom_range(0, 20);
                2: r.value = -$urandom_range(1, 20);
                3: r.value = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                default: r.value = $urandom;
            endcase
            r.width = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                  : 6'($urandom_range(0, 16));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: r.precision = 7'(-1);
                4: r.precision = 7'($urandom_range(64, 126));
                5: r.precision = 7'd0;
                6: r.precision = 7'($urandom_range(0, 63));
                default: r.precision = 7'($urandom_range(1, 12));
            endcase
            r.zero_pad = 1'($urandom_range(0, 1));
            r.left_justify = ($urandom_range(0, 2) == 0);
            request_q.push_back(r);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all words to be taken and every character checked
        while (!timed_out && (request_q.size() > 0 || in_valid || expected_chars.size() > 0))
        begin
            @(posedge clk);
            if (cycles > CYCLE_LIMIT)
                timed_out = 1'b1;
        end
        if (!timed_out)
            repeat (DRAIN_CYCLES) @(posedge clk);

        if (timed_out)
            $display("tb: failure");
        else if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
